// File: src/knorm_pkg.sv
// ----------------------------------------------------------------------------
// knorm_pkg: shared types and tables for the kana normalizer
// Result record, code point limits and the half-width, voiced, semi-voiced
// and long-vowel lookup tables.
// ----------------------------------------------------------------------------
`default_nettype none

package knorm_pkg;

  // Default saturation limit of the consumed point count
  localparam int MAX_TEXT = 256;

  localparam int CP_W  = 21;
  localparam int CNT_W = 9;

  // One result request on the output channel
  typedef struct packed {
    logic [CP_W-1:0]  code_point;
    logic [CNT_W-1:0] consumed_count;
    logic             is_empty;
    logic             last;
  } res_t;

  // UTF-16 and character range limits
  localparam logic [15:0] CU_LOW_SURR   = 16'hDC00;
  localparam logic [CP_W-1:0] CP_SUPP   = 21'h010000;
  localparam logic [CP_W-1:0] CP_END    = 21'h003000;
  localparam logic [CP_W-1:0] CP_WAVE   = 21'h00FF5E;
  localparam logic [CP_W-1:0] CP_VOICED = 21'h00FF9E;
  localparam logic [CP_W-1:0] CP_SEMI   = 21'h00FF9F;
  localparam logic [CP_W-1:0] CP_LONG   = 21'h0030FC;
  localparam logic [CP_W-1:0] KATA_LO   = 21'h0030A1;
  localparam logic [CP_W-1:0] KATA_HI   = 21'h0030F3;
  localparam logic [CP_W-1:0] KATA_OFS  = 21'h000060;
  localparam logic [CP_W-1:0] HALF_LO   = 21'h00FF66;
  localparam logic [CP_W-1:0] HALF_HI   = 21'h00FF9D;
  localparam logic [CP_W-1:0] VOI_LO    = 21'h00FF73;
  localparam logic [CP_W-1:0] VOI_HI    = 21'h00FF8E;
  localparam logic [CP_W-1:0] SEMI_LO   = 21'h00FF8A;
  localparam logic [CP_W-1:0] HIRA_LO   = 21'h003041;
  localparam logic [CP_W-1:0] HIRA_HI   = 21'h003094;

  localparam logic [15:0] KV_A = 16'h3042;
  localparam logic [15:0] KV_I = 16'h3044;
  localparam logic [15:0] KV_U = 16'h3046;
  localparam logic [15:0] KV_L = 16'h30FC;
  localparam logic [15:0] KV_0 = 16'h0000;

  // Half-width katakana U+FF66..U+FF9D to hiragana
  localparam logic [15:0] HALF_TAB [56] = '{
    16'h3092, 16'h3041, 16'h3043, 16'h3045, 16'h3047, 16'h3049, 16'h3083,
    16'h3085, 16'h3087, 16'h3063, 16'h30FC, 16'h3042, 16'h3044, 16'h3046,
    16'h3048, 16'h304A, 16'h304B, 16'h304D, 16'h304F, 16'h3051, 16'h3053,
    16'h3055, 16'h3057, 16'h3059, 16'h305B, 16'h305D, 16'h305F, 16'h3061,
    16'h3064, 16'h3066, 16'h3068, 16'h306A, 16'h306B, 16'h306C, 16'h306D,
    16'h306E, 16'h306F, 16'h3072, 16'h3075, 16'h3078, 16'h307B, 16'h307E,
    16'h307F, 16'h3080, 16'h3081, 16'h3082, 16'h3084, 16'h3086, 16'h3088,
    16'h3089, 16'h308A, 16'h308B, 16'h308C, 16'h308D, 16'h308F, 16'h3093
  };

  // Voiced forms, indexed by previous raw point minus U+FF73
  localparam logic [15:0] VOICED_TAB [28] = '{
    16'h30F4, 16'hFF74, 16'hFF75, 16'h304C, 16'h304E, 16'h3050, 16'h3052,
    16'h3054, 16'h3056, 16'h3058, 16'h305A, 16'h305C, 16'h305E, 16'h3060,
    16'h3062, 16'h3065, 16'h3067, 16'h3069, 16'hFF85, 16'hFF86, 16'hFF87,
    16'hFF88, 16'hFF89, 16'h3070, 16'h3073, 16'h3076, 16'h3079, 16'h307C
  };

  // Semi-voiced forms, indexed by previous raw point minus U+FF8A
  localparam logic [15:0] SEMI_TAB [8] = '{
    16'h3071, 16'h3074, 16'h3077, 16'h307A, 16'h307D,
    16'h0000, 16'h0000, 16'h0000
  };

  // Vowel for a long-vowel mark, indexed by held hiragana minus U+3041
  localparam logic [15:0] VOWEL_TAB [128] = '{
    KV_L, KV_A, KV_L, KV_I, KV_L, KV_U, KV_L, KV_I,
    KV_L, KV_U, KV_A, KV_A, KV_I, KV_I, KV_U, KV_U,
    KV_I, KV_I, KV_U, KV_U, KV_A, KV_A, KV_I, KV_I,
    KV_U, KV_U, KV_I, KV_I, KV_U, KV_U, KV_A, KV_A,
    KV_I, KV_I, KV_0, KV_U, KV_U, KV_I, KV_I, KV_U,
    KV_U, KV_A, KV_I, KV_U, KV_I, KV_U, KV_A, KV_A,
    KV_A, KV_I, KV_I, KV_I, KV_U, KV_U, KV_U, KV_I,
    KV_I, KV_I, KV_U, KV_U, KV_U, KV_A, KV_I, KV_U,
    KV_I, KV_U, KV_A, KV_A, KV_U, KV_U, KV_U, KV_U,
    KV_A, KV_I, KV_U, KV_I, KV_U, KV_L, KV_A, KV_I,
    KV_I, KV_0, KV_0, KV_L, KV_0, KV_0, KV_0, KV_0,
    KV_0, KV_0, KV_0, KV_0, KV_0, KV_0, KV_0, KV_0,
    KV_0, KV_0, KV_0, KV_0, KV_0, KV_0, KV_0, KV_0,
    KV_0, KV_0, KV_0, KV_0, KV_0, KV_0, KV_0, KV_0,
    KV_0, KV_0, KV_0, KV_0, KV_0, KV_0, KV_0, KV_0,
    KV_0, KV_0, KV_0, KV_0, KV_0, KV_0, KV_0, KV_0
  };

endpackage

`default_nettype wire

// File: src/kana_normalizer_top.sv
// ----------------------------------------------------------------------------
// kana_normalizer_top: UTF-16 to hiragana folding stream
// Top level: folding stage, output buffer and port mapping.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall/in_code_unit carries one UTF-16 code unit
//   per request. Output channel out_valid/out_stall carries one folded
//   character with its consumed point count, an empty flag and a last flag.
//   A character is released when the next character or the end of text
//   arrives, since a following voiced mark may still replace it.
//   Throughput: one code unit per cycle while in_stall is low, set by the single fold stage.
//   A result is registered in the output register, or in the skid stage while
//   the receiver stalls, when the unit that releases it is accepted.
//   Reset (rst_n low, synchronous) empties the output and clears all text
//   state. When the receiver stalls, the output register holds its request
//   and one more result goes to the skid stage; in_stall rises only while
//   that skid stage is occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module kana_normalizer_top #(
  parameter int MaxText = knorm_pkg::MAX_TEXT
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_code_unit,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [20:0]      out_code_point,
  output logic [8:0]       out_consumed_count,
  output logic             out_is_empty,
  output logic             out_last
);
  import knorm_pkg::*;

  logic acc;
  logic res_vld;
  res_t res, out_data;

  assign acc = in_valid && !in_stall;

  // Fold stage
  knorm_fold #(
    .MaxText(MaxText)
  ) u_fold (
    .clk    (clk),
    .rst_n  (rst_n),
    .acc    (acc),
    .unit   (in_code_unit),
    .res_vld(res_vld),
    .res    (res)
  );

  // Result register and skid stage
  knorm_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (acc && res_vld),
    .push_data(res),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .out_data (out_data),
    .full     (in_stall)
  );

  // Break out result fields
  assign out_code_point     = out_data.code_point;
  assign out_consumed_count = out_data.consumed_count;
  assign out_is_empty       = out_data.is_empty;
  assign out_last           = out_data.last;

`ifndef NO_ASSERTIONS
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid && !in_stall)
    else $error("output not empty after reset");

  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("skid occupied while output register empty");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_empty |-> out_last && out_code_point == '0
      && out_consumed_count == '0)
    else $error("empty marker malformed");

  a_stall_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall && acc && res_vld |=> in_stall)
    else $error("result lost while output stalled");
`endif

endmodule

`default_nettype wire

// File: src/knorm_fold.sv
// ----------------------------------------------------------------------------
// knorm_fold: surrogate pairing, kana folding and hold-back state
// Updates the text state on each accepted code unit and produces at most
// one result request for the output buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module knorm_fold #(
  parameter int MaxText = knorm_pkg::MAX_TEXT
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        acc,
  input  wire logic [15:0] unit,
  output logic             res_vld,
  output knorm_pkg::res_t  res
);
  import knorm_pkg::*;

  localparam int CW = $clog2(MaxText + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MaxText);

  logic            held_valid_r, held_valid_nxt;
  logic [CP_W-1:0] held_char_r, held_char_nxt;
  logic [CW-1:0]   held_count_r, held_count_nxt;
  logic [CP_W-1:0] prev_raw_r, prev_raw_nxt;
  logic            high_pending_r, high_pending_nxt;
  logic [9:0]      high_bits_r, high_bits_nxt;
  logic [CW-1:0]   point_count_r, point_count_nxt;

  logic            is_hi, is_lo, has_point;
  logic [CP_W-1:0] cp, conv;
  logic [CW-1:0]   cnt_inc;
  logic [15:0]     half_ofs, voi_ofs, semi_ofs, hira_ofs;
  logic [15:0]     vowel;

  // Classify the code unit
  assign is_hi = (unit[15:10] == 6'b110110);
  assign is_lo = (unit[15:10] == 6'b110111);

  // Table offsets; only used when the range check passes
  assign half_ofs = cp[15:0] - HALF_LO[15:0];
  assign voi_ofs  = prev_raw_r[15:0] - VOI_LO[15:0];
  assign semi_ofs = prev_raw_r[15:0] - SEMI_LO[15:0];
  assign hira_ofs = held_char_r[15:0] - HIRA_LO[15:0];
  assign vowel    = VOWEL_TAB[hira_ofs[6:0]];

  // Saturating point count
  assign cnt_inc = (point_count_r < CNT_MAX) ? point_count_r + CW'(1) : point_count_r;

  // Pair surrogates into one code point
  always_comb begin
    has_point = 1'b1;
    if (high_pending_r && is_lo) begin
      cp = CP_SUPP + {1'b0, high_bits_r, unit[9:0]};
    end else begin
      cp = {5'b0, unit};
      if (is_hi) begin
        has_point = 1'b0;
      end
    end
  end

  // Fold katakana, half-width katakana and long-vowel marks for a plain character
  always_comb begin
    conv = cp;
    if (cp >= KATA_LO && cp <= KATA_HI) begin
      conv = cp - KATA_OFS;
    end else if (cp >= HALF_LO && cp <= HALF_HI) begin
      conv = {5'b0, HALF_TAB[half_ofs[5:0]]};
    end else if (cp == CP_LONG && held_valid_r && held_char_r >= HIRA_LO
                 && held_char_r <= HIRA_HI && vowel != KV_0) begin
      conv = {5'b0, vowel};
    end
  end

  // Next text state and result request
  always_comb begin
    held_valid_nxt   = held_valid_r;
    held_char_nxt    = held_char_r;
    held_count_nxt   = held_count_r;
    prev_raw_nxt     = prev_raw_r;
    high_pending_nxt = 1'b0;
    high_bits_nxt    = high_bits_r;
    point_count_nxt  = point_count_r;
    res_vld          = 1'b0;
    res              = '0;
    res.code_point     = held_char_r;
    res.consumed_count = CNT_W'(held_count_r);

    if (!has_point) begin
      // Wait for the low half
      high_pending_nxt = 1'b1;
      high_bits_nxt    = unit[9:0];
    end else if (cp <= CP_END || cp == CP_WAVE) begin
      // End of text: flush held character or send the empty marker
      res_vld  = 1'b1;
      res.last = 1'b1;
      if (!held_valid_r) begin
        res.code_point     = '0;
        res.consumed_count = '0;
        res.is_empty       = 1'b1;
      end
      held_valid_nxt  = 1'b0;
      held_char_nxt   = '0;
      held_count_nxt  = '0;
      prev_raw_nxt    = '0;
      high_bits_nxt   = '0;
      point_count_nxt = '0;
    end else begin
      point_count_nxt = cnt_inc;
      prev_raw_nxt    = cp;
      held_count_nxt  = cnt_inc;
      if (held_valid_r && cp == CP_VOICED && prev_raw_r >= VOI_LO
          && prev_raw_r <= VOI_HI) begin
        // Merge voiced mark into the held character
        held_char_nxt = {5'b0, VOICED_TAB[voi_ofs[4:0]]};
      end else if (held_valid_r && cp == CP_SEMI && prev_raw_r >= SEMI_LO
                   && prev_raw_r <= VOI_HI) begin
        // Merge semi-voiced mark into the held character
        held_char_nxt = {5'b0, SEMI_TAB[semi_ofs[2:0]]};
      end else begin
        // Release the held character and hold the new one
        res_vld        = held_valid_r;
        held_valid_nxt = 1'b1;
        held_char_nxt  = conv;
      end
    end
  end

  // Advance text state on each accepted unit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r   <= 1'b0;
      held_char_r    <= '0;
      held_count_r   <= '0;
      prev_raw_r     <= '0;
      high_pending_r <= 1'b0;
      high_bits_r    <= '0;
      point_count_r  <= '0;
    end else if (acc) begin
      held_valid_r   <= held_valid_nxt;
      held_char_r    <= held_char_nxt;
      held_count_r   <= held_count_nxt;
      prev_raw_r     <= prev_raw_nxt;
      high_pending_r <= high_pending_nxt;
      high_bits_r    <= high_bits_nxt;
      point_count_r  <= point_count_nxt;
    end
  end

endmodule

`default_nettype wire

// File: src/knorm_out_buf.sv
// ----------------------------------------------------------------------------
// knorm_out_buf: result register with skid stage
// Holds result requests for the output channel and keeps the input side
// running while the receiver stalls, until the skid stage is occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module knorm_out_buf (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire knorm_pkg::res_t push_data,
  input  wire logic            out_stall,
  output logic                 out_valid,
  output knorm_pkg::res_t      out_data,
  output logic                 full
);
  import knorm_pkg::*;

  logic out_valid_r, skid_valid_r;
  res_t out_data_r, skid_data_r;
  logic out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign full      = skid_valid_r;

  // Control: refill from skid first, else take the new request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r  <= skid_valid_r || push;
      skid_valid_r <= 1'b0;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Payload: move data without reset
  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data_r <= skid_valid_r ? skid_data_r : push_data;
    end else if (push) begin
      skid_data_r <= push_data;
    end
  end

endmodule

`default_nettype wire
